[rtl/setr_pkg.sv]
package setr_pkg;

  // Ring geometry; depth must be a power of two (slot = low sequence bits)
  localparam int RING_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int KIND_COUNT = 13;
  localparam int MAX_READ   = 64;
  localparam int SEQ_W      = 64;
  localparam int LIMIT_W    = 7;
  localparam int CNT_W      = $clog2(MAX_READ + 1);

  localparam int IN_DATA_W  = 440;
  localparam int OUT_DATA_W = 496;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = KIND_COUNT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECORDING = 1'b0,
    CFG_KIND_MASK = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic [63:0] time_stamp;
    logic [3:0]  kind;
    logic [7:0]  cpu;
    logic [31:0] thread;
    logic [63:0] node;
    logic [63:0] first;
    logic [63:0] second;
    logic [63:0] third;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic accept_rec;
    logic accept_read;
    logic clamp;
    logic issue;
    logic load_rec;
    logic load_empty;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_read;
    logic can_issue;
    logic iss_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/setr_ctrl.sv]
module setr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  setr_pkg::sts_t sts,
  output setr_pkg::cmd_t cmd
);
  import setr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLAMP = 5'b00010,
    ST_FIRST = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_EMPTY = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (sts.in_is_read) begin
            cmd.accept_read = 1'b1;
            state_next      = ST_CLAMP;
          end else begin
            cmd.accept_rec = 1'b1;
          end
        end
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (sts.can_issue) begin
          cmd.issue  = 1'b1;
          state_next = ST_LOAD;
        end else begin
          state_next = ST_EMPTY;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_rec = 1'b1;
          if (sts.iss_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.issue = 1'b1;
          end
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_rec || cmd.load_empty) |-> sts.out_free)
    else $error("result loaded while output busy");
`endif

endmodule

[rtl/setr_dpath.sv]
module setr_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [setr_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [setr_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [setr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [setr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  setr_pkg::cmd_t                     cmd,
  output setr_pkg::sts_t                     sts
);
  import setr_pkg::*;

  // input word unpacking
  logic [3:0]         in_kind;
  logic [LIMIT_W-1:0] in_limit;
  logic [SEQ_W-1:0]   in_cursor;
  slot_t              in_slot;

  assign in_kind            = s_tdata[3:0];
  assign in_slot.kind       = s_tdata[3:0];
  assign in_slot.node       = s_tdata[67:4];
  assign in_slot.first      = s_tdata[131:68];
  assign in_slot.second     = s_tdata[195:132];
  assign in_slot.third      = s_tdata[259:196];
  assign in_slot.time_stamp = s_tdata[323:260];
  assign in_slot.cpu        = s_tdata[331:324];
  assign in_slot.thread     = s_tdata[363:332];
  assign in_cursor          = s_tdata[427:364];
  assign in_limit           = s_tdata[434:428];

  // configuration
  logic                  recording_on;
  logic [KIND_COUNT-1:0] kind_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      recording_on <= 1'b1;
      kind_mask    <= KIND_COUNT'(7487);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RECORDING: recording_on <= cfg_data[0];
        CFG_KIND_MASK: kind_mask    <= cfg_data[KIND_COUNT-1:0];
        default: ;
      endcase
    end
  end

  logic [15:0] mask_ext;
  logic        rec_ok;
  logic        wr_en;

  assign mask_ext = 16'(kind_mask);
  assign rec_ok   = recording_on && (5'(in_kind) < 5'(KIND_COUNT)) && mask_ext[in_kind];
  assign wr_en    = cmd.accept_rec && rec_ok;

  // sequence head and oldest held sequence (oldest follows head in the next cycle)
  logic [SEQ_W-1:0] head;
  logic [SEQ_W-1:0] oldest;

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      oldest <= '0;
    end else begin
      if (wr_en) begin
        head <= head + SEQ_W'(1);
      end
      oldest <= (head > SEQ_W'(RING_DEPTH)) ? head - SEQ_W'(RING_DEPTH) : '0;
    end
  end

  // slot store
  slot_t mem [RING_DEPTH];
  slot_t rd_data;

  // read walk
  logic [SEQ_W-1:0]   cursor;
  logic [SEQ_W-1:0]   pos;
  logic [SEQ_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_inc;
  logic [SEQ_W-1:0]   iss_seq;
  logic               iss_last;

  assign pos_inc = pos + SEQ_W'(1);
  assign cnt_inc = cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head[ADDR_W-1:0]] <= in_slot;
    end
    if (cmd.issue) begin
      rd_data <= mem[pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_read) begin
      cursor <= in_cursor;
      lim    <= (in_limit > LIMIT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : CNT_W'(in_limit);
    end
    if (cmd.clamp) begin
      pos <= (cursor < oldest) ? oldest : cursor;
      cnt <= '0;
    end else if (cmd.issue) begin
      pos      <= pos_inc;
      cnt      <= cnt_inc;
      iss_seq  <= pos;
      iss_last <= (pos_inc == head) || (cnt_inc == lim);
    end
  end

  // output register
  logic             out_valid;
  logic [SEQ_W-1:0] out_seq;
  logic [SEQ_W-1:0] out_next;
  logic             out_last;
  slot_t            out_slot;
  logic             out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_rec || cmd.load_empty) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rec) begin
      out_valid <= 1'b1;
      out_seq   <= iss_seq;
      out_slot  <= rd_data;
      out_last  <= iss_last;
      out_next  <= iss_last ? pos : '0;
    end else if (cmd.load_empty) begin
      out_valid <= 1'b0;
      out_seq   <= '0;
      out_slot  <= '0;
      out_last  <= 1'b1;
      out_next  <= pos;
    end
  end

  assign m_tdata = {4'b0, out_next, out_slot.third, out_slot.second, out_slot.first,
                    out_slot.node, out_slot.thread, out_slot.cpu, out_slot.kind,
                    out_slot.time_stamp, out_seq};
  assign m_tuser = out_valid;
  assign m_tlast = out_last;

  assign sts.in_is_read = (op_t'(s_tuser) == OP_READ);
  assign sts.can_issue  = (pos < head) && (lim != '0);
  assign sts.iss_last   = iss_last;
  assign sts.out_free   = out_free;

`ifndef ASSERT_OFF
  // each stored record advances the head by exactly one
  a_head_step: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> head == $past(head) + SEQ_W'(1))
    else $error("head did not advance on record");

  // a slot is only fetched for a sequence below the head
  a_issue_held: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> pos < head)
    else $error("fetch beyond head");

  // no record is written while a read walk is in progress
  a_no_wr_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !wr_en)
    else $error("write during read walk");
`endif

endmodule

[rtl/sequenced_event_trace_ring.sv]
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  s_tuser operation; s_tdata record or read request
// m_*       out  m_tvalid/m_tready  m_tuser record_valid; m_tlast last_of_read; m_tdata result
// cfg_*     in   cfg_we             cfg_index register, cfg_data value
//
// An enabled record word is written to its slot at the same edge that takes it.
// A read word goes through setup (accept, cursor clamp, first fetch), then gives
// one result per cycle from the registered slot memory read port while the
// output is not stalled; an empty read gives its single result after the same setup.
// A stalled m_tready holds the walk; the next input word is taken once the
// last result of a read sits in the output register.
// Reset (rst, sync): head sequence 0, recording on, kind mask 7487; the slot
// memory is not cleared.
module sequenced_event_trace_ring (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // lsb up: event_kind, node_ident, arg_first, arg_second, arg_third,
  // time_stamp, cpu_number, thread_ident, read_cursor, read_limit, zero pad
  input  logic [setr_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // lsb up: sequence_number, out_time, out_kind, out_cpu, out_thread,
  // out_node, out_first, out_second, out_third, next_cursor, zero pad
  output logic [setr_pkg::OUT_DATA_W-1:0] m_tdata,
  // record_valid
  output logic                            m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [setr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [setr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import setr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: accept, clamp, fetch/load loop
  setr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot memory, head counter, read walk and output register
  setr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[bench/setr_tb_pkg.sv]
package setr_tb_pkg;

  import setr_pkg::*;

  localparam logic [KIND_COUNT-1:0] KIND_MASK_AT_RESET = 13'd7487;
  localparam logic [KIND_COUNT-1:0] KIND_MASK_ALL      = '1;

  // s_tdata layout, msb first (event_kind sits in the low bits)
  typedef struct packed {
    logic [4:0]         pad;
    logic [LIMIT_W-1:0] limit;
    logic [SEQ_W-1:0]   cursor;
    logic [31:0]        thread;
    logic [7:0]         cpu;
    logic [63:0]        stamp;
    logic [63:0]        arg_third;
    logic [63:0]        arg_second;
    logic [63:0]        arg_first;
    logic [63:0]        node;
    logic [3:0]         kind;
  } req_word_t;

  // m_tdata layout, msb first (sequence number sits in the low bits)
  typedef struct packed {
    logic [3:0]       pad;
    logic [SEQ_W-1:0] next_cursor;
    logic [63:0]      arg_third;
    logic [63:0]      arg_second;
    logic [63:0]      arg_first;
    logic [63:0]      node;
    logic [31:0]      thread;
    logic [7:0]       cpu;
    logic [3:0]       kind;
    logic [63:0]      stamp;
    logic [SEQ_W-1:0] seq;
  } trace_word_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    trace_word_t word;
  } trace_result_t;

endpackage

[bench/trace_ring_checker.sv]
module trace_ring_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [setr_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [setr_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tuser,
  input  logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [setr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [setr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              words_owed,
  output logic [setr_pkg::SEQ_W-1:0]      ring_head
);
  timeunit 1ns;
  timeprecision 1ps;

  import setr_pkg::*;
  import setr_tb_pkg::*;

  logic                  recording_on_q;
  logic [KIND_COUNT-1:0] kind_mask_q;
  logic [SEQ_W-1:0]      head_seq;
  slot_t                 ring_copy [RING_DEPTH];
  trace_result_t         owed_q [$];

  task automatic log_event(input req_word_t w);
    slot_t s;
    if (recording_on_q && w.kind < KIND_COUNT) begin
      if (kind_mask_q[w.kind]) begin
        s.time_stamp = w.stamp;
        s.kind       = w.kind;
        s.cpu        = w.cpu;
        s.thread     = w.thread;
        s.node       = w.node;
        s.first      = w.arg_first;
        s.second     = w.arg_second;
        s.third      = w.arg_third;
        ring_copy[head_seq[ADDR_W-1:0]] = s;
        head_seq = head_seq + SEQ_W'(1);
      end
    end
  endtask

  task automatic replay_read(input req_word_t w);
    logic [SEQ_W-1:0] oldest;
    logic [SEQ_W-1:0] pos;
    logic [SEQ_W-1:0] avail;
    int unsigned      cap;
    int unsigned      n;
    slot_t            s;
    trace_result_t    r;
    oldest = (head_seq > RING_DEPTH) ? head_seq - SEQ_W'(RING_DEPTH) : '0;
    pos    = (w.cursor < oldest) ? oldest : w.cursor;
    cap    = (w.limit > MAX_READ) ? MAX_READ : 32'(w.limit);
    avail  = (pos < head_seq) ? head_seq - pos : '0;
    n      = (avail < cap) ? 32'(avail) : cap;
    if (n == 0) begin
      // empty read: one blank word that carries the clamped cursor
      r = '0;
      r.last = 1'b1;
      r.word.next_cursor = pos;
      owed_q.push_back(r);
    end
    for (int unsigned i = 0; i < n; i++) begin
      s = ring_copy[pos[ADDR_W-1:0]];
      r = '0;
      r.valid           = 1'b1;
      r.last            = (i == n - 1);
      r.word.seq        = pos;
      r.word.stamp      = s.time_stamp;
      r.word.kind       = s.kind;
      r.word.cpu        = s.cpu;
      r.word.thread     = s.thread;
      r.word.node       = s.node;
      r.word.arg_first  = s.first;
      r.word.arg_second = s.second;
      r.word.arg_third  = s.third;
      pos = pos + SEQ_W'(1);
      if (r.last)
        r.word.next_cursor = pos;
      owed_q.push_back(r);
    end
  endtask

  task automatic match_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    req_word_t     req;
    trace_word_t   got;
    trace_result_t want;
    if (rst) begin
      recording_on_q = 1'b1;
      kind_mask_q    = KIND_MASK_AT_RESET;
      head_seq       = '0;
      owed_q.delete();
      fail_count     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RECORDING: recording_on_q = cfg_data[0];
          CFG_KIND_MASK: kind_mask_q = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        req = s_tdata;
        if (op_t'(s_tuser) == OP_READ)
          replay_read(req);
        else
          log_event(req);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual seq %h",
                   $time, got.seq);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          match_field("record_valid", 64'(want.valid), 64'(m_tuser));
          match_field("last_of_read", 64'(want.last), 64'(m_tlast));
          match_field("sequence_number", want.word.seq, got.seq);
          match_field("out_time", want.word.stamp, got.stamp);
          match_field("out_kind", 64'(want.word.kind), 64'(got.kind));
          match_field("out_cpu", 64'(want.word.cpu), 64'(got.cpu));
          match_field("out_thread", 64'(want.word.thread), 64'(got.thread));
          match_field("out_node", want.word.node, got.node);
          match_field("out_first", want.word.arg_first, got.arg_first);
          match_field("out_second", want.word.arg_second, got.arg_second);
          match_field("out_third", want.word.arg_third, got.arg_third);
          match_field("next_cursor", want.word.next_cursor, got.next_cursor);
        end
      end
    end
    words_owed = owed_q.size();
    ring_head  = head_seq;
  end

endmodule

[bench/sequenced_event_trace_ring_tb.sv]
module sequenced_event_trace_ring_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import setr_pkg::*;
  import setr_tb_pkg::*;

  // block needs no handshake wait for records, so a short pause is enough
  // before a register write
  localparam int SETTLE_CYCLES = 6;
  // a read waits for its setup steps plus receiver stalls
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int FILL_COUNT    = 1100;
  localparam int PHASE_ITEMS   = 200;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int               fail_count;
  int               words_owed;
  logic [SEQ_W-1:0] ring_head;
  int               send_idle_pct = 22;
  int               recv_idle_pct = 67;
  int               quiet_cycles  = 0;

  always #5 clk = ~clk;

  sequenced_event_trace_ring dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  trace_ring_checker ring_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .words_owed (words_owed),
    .ring_head  (ring_head)
  );

  // receiver back-pressure, one decision per cycle
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // stall watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[sequenced_event_trace_ring] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // every field but the pad random; callers overwrite what matters for the operation
  function automatic req_word_t random_word();
    req_word_t w;
    w.pad        = '0;
    w.limit      = LIMIT_W'($urandom_range(0, 127));
    w.cursor     = rand64();
    w.thread     = $urandom;
    w.cpu        = 8'($urandom_range(0, 255));
    w.stamp      = rand64();
    w.arg_third  = rand64();
    w.arg_second = rand64();
    w.arg_first  = rand64();
    w.node       = rand64();
    w.kind       = 4'($urandom_range(0, 15));
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is
  // taken. tvalid stays high so back-to-back words need no extra assignment.
  task automatic push_word(input op_t op, input req_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = w;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic record_event(input logic [3:0] kind);
    req_word_t w;
    w = random_word();
    w.kind = kind;
    push_word(OP_RECORD, w);
  endtask

  task automatic read_from(input logic [SEQ_W-1:0] cursor, input logic [6:0] limit);
    req_word_t w;
    w = random_word();
    w.cursor = cursor;
    w.limit  = limit;
    push_word(OP_READ, w);
  endtask

  // hold the sender until every owed word is out, then let the block settle
  task automatic quiesce();
    s_tvalid = 1'b0;
    while (words_owed != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  // Mixed traffic: mostly records and reads near the head, with stale,
  // oldest-edge, past-head and fully random cursors mixed in.
  task automatic random_traffic(input int count, input int pause_at);
    logic [SEQ_W-1:0] cursor;
    logic [6:0]       limit;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at)
        quiesce();
      if ($urandom_range(99) < 60) begin
        record_event(4'(($urandom_range(99) < 90) ? $urandom_range(0, KIND_COUNT - 1)
                                                    : $urandom_range(KIND_COUNT, 15)));
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: cursor = ring_head - $urandom_range(0, 80);
          4:          cursor = ring_head - $urandom_range(RING_DEPTH - 24, RING_DEPTH + 16);
          5, 6:       cursor = (ring_head > RING_DEPTH + 64)
                               ? ring_head - RING_DEPTH - $urandom_range(1, 64) : '0;
          7:          cursor = ring_head + $urandom_range(0, 3);
          default:    cursor = rand64();
        endcase
        limit = 7'(($urandom_range(99) < 80) ? $urandom_range(0, 24)
                                             : $urandom_range(0, 127));
        read_from(cursor, limit);
      end
    end
  endtask

  initial begin : stimulus
    req_word_t w;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part ---
    read_from('0, 7'd5);                // nothing recorded yet
    read_from('1, 7'd0);                // zero limit at the top cursor
    w = '0;
    push_word(OP_RECORD, w);            // all-zero record, kind 0
    w = '1;
    w.pad  = '0;
    w.kind = 4'(KIND_COUNT - 1);
    push_word(OP_RECORD, w);            // all-ones record, highest kind
    record_event(4'd6);                 // kind masked off at reset
    record_event(4'd13);                // first kind past the count
    record_event(4'd15);
    record_event(4'd5);
    read_from('0, 7'd127);              // limit saturates, returns all three
    read_from(64'd1, 7'd1);             // single word, cursor moves by one
    read_from(ring_head, 7'd10);        // cursor sitting on the head
    read_from(64'hFFFF_FFFF_FFFF_FFF0, 7'd64);

    // recording off: upper data bits set to make sure only bit 0 counts
    quiesce();
    write_reg(CFG_RECORDING, 13'h1FFE);
    record_event(4'd0);
    quiesce();
    write_reg(CFG_RECORDING, 13'd1);
    write_reg(CFG_KIND_MASK, '0);
    record_event(4'd3);                 // every kind disabled
    quiesce();
    write_reg(CFG_KIND_MASK, KIND_MASK_ALL);
    record_event(4'd9);
    record_event(4'd14);                // still rejected with the mask full
    read_from('0, 7'd64);

    // --- wrap the ring so stale cursors get clamped ---
    for (int i = 0; i < FILL_COUNT; i++)
      record_event(4'($urandom_range(0, KIND_COUNT - 1)));

    // --- random part, three idle profiles ---
    random_traffic(PHASE_ITEMS, PHASE_ITEMS / 2);

    quiesce();
    send_idle_pct = 67;
    recv_idle_pct = 22;
    write_reg(CFG_KIND_MASK, CFG_DATA_W'($urandom_range(0, 8191)));
    random_traffic(PHASE_ITEMS, -1);

    quiesce();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_KIND_MASK, KIND_MASK_AT_RESET);
    random_traffic(PHASE_ITEMS, -1);

    // drain, then stay quiet for DRAIN_CYCLES to catch stray words
    s_tvalid = 1'b0;
    while (words_owed != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[sequenced_event_trace_ring] OK");
    else
      $display("[sequenced_event_trace_ring] ERROR");
    $finish;
  end

endmodule
